### src/bgms_pkg.sv
// Shared constants and types for the budget greedy max-count selector.
`timescale 1ns / 1ps
package bgms_pkg;

	// Default store depth and price width
	localparam int MAX_ITEMS_DEF  = 256;
	localparam int PRICE_BITS_DEF = 32;

	// Fixed field widths
	localparam int BUDGET_W = 32;
	localparam int COUNT_W  = 9;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	// Register index, taken from paddr[2]
	localparam logic REG_BUDGET = 1'b0;

	// Operation that every cell of the chain performs
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_POP,
		CELL_INS
	} cell_op_t;

endpackage

### src/budget_greedy_max_count_select_top.sv
// A result beat is loaded into the output register from the decision state that
// follows acceptance of its price beat, later while the output stalls.
// No new price is taken before the held one is decided; one that replaces the largest
// chosen price also holds the input through the chain's pop state before its insert.
// Reset clears count, total, overflow, budget and all handshake state; the
// price chain is not cleared, only entries below the count are ever used.
`timescale 1ns / 1ps
module budget_greedy_max_count_select_top #(
	parameter int MAX_ITEMS  = bgms_pkg::MAX_ITEMS_DEF,
	parameter int PRICE_BITS = bgms_pkg::PRICE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgms_pkg::ADDR_W-1:0]   paddr,
	input  logic [bgms_pkg::DATA_W-1:0]   pwdata,
	output logic [bgms_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// price input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   price,
	input  logic                          last,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bgms_pkg::COUNT_W-1:0]  chosen_count,
	output logic [31:0]                   chosen_total,
	output logic                          overflow,
	output logic                          final_res
);
	import bgms_pkg::*;

	localparam int PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ITEMS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_POP,
		S_INS
	} state_t;

	state_t              state_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [PW-1:0]       price_q;
	logic                last_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         total_q;
	logic                ovf_q;
	logic [CW-1:0]       ins_cnt_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [31:0]         out_total_q;
	logic                out_ovf_q;
	logic                out_final_q;

	logic [PW-1:0]       head;
	cell_op_t            cell_op;
	logic                in_fire;
	logic                cfg_wr;
	logic                slot_free;
	logic                decide;
	logic [32:0]         price_ext;
	logic [32:0]         head_ext;
	logic [32:0]         sum;
	logic                fits_budget;
	logic                fits_room;
	logic                do_append;
	logic                do_replace;
	logic                do_drop;
	logic [CW-1:0]       nxt_count;
	logic [31:0]         nxt_total;
	logic                nxt_ovf;
	logic [CW+COUNT_W-1:0] cnt_wide;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_BUDGET) ? budget_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_BUDGET) begin
			budget_q <= pwdata;
		end
	end

	// Input handshake: take a beat while idle or while the chain finishes an insert
	assign in_stall = !(state_q == S_IDLE || state_q == S_INS);
	assign in_fire  = in_valid && !in_stall;

	// Decision arithmetic on the held price
	assign price_ext   = 33'(price_q);
	assign head_ext    = 33'(head);
	assign sum         = 33'(total_q) + price_ext;
	assign fits_budget = price_ext <= 33'(budget_q);
	assign fits_room   = sum <= 33'(budget_q);
	assign do_append   = fits_budget && fits_room && (count_q != FULL_CNT);
	assign do_drop     = fits_budget && fits_room && (count_q == FULL_CNT);
	assign do_replace  = fits_budget && !fits_room && (count_q != '0) &&
		(price_ext < head_ext);

	always_comb begin
		nxt_count = count_q;
		nxt_total = total_q;
		nxt_ovf   = ovf_q;
		if (do_append) begin
			nxt_count = count_q + CW'(1);
			nxt_total = sum[31:0];
		end else if (do_replace) begin
			nxt_total = total_q - 32'(head) + 32'(price_q);
		end
		if (do_drop) begin
			nxt_ovf = 1'b1;
		end
	end

	assign cnt_wide  = (CW + COUNT_W)'(nxt_count);
	assign slot_free = !(out_valid_q && out_stall);
	assign decide    = (state_q == S_DECIDE) && slot_free;

	// Chain operation follows the state
	always_comb begin
		unique case (state_q)
			S_POP:   cell_op = CELL_POP;
			S_INS:   cell_op = CELL_INS;
			default: cell_op = CELL_HOLD;
		endcase
	end

	// Sequencer: hold state, set counters and launch chain operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			total_q   <= '0;
			ovf_q     <= 1'b0;
			ins_cnt_q <= '0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE, S_INS: begin
					if (in_fire) begin
						last_q  <= last;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DECIDE: begin
					if (slot_free) begin
						if (last_q) begin
							count_q <= '0;
							total_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							count_q <= nxt_count;
							total_q <= nxt_total;
							ovf_q   <= nxt_ovf;
							if (do_append) begin
								ins_cnt_q <= count_q;
								state_q   <= S_INS;
							end else if (do_replace) begin
								ins_cnt_q <= count_q - CW'(1);
								state_q   <= S_POP;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_POP: begin
					state_q <= S_INS;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted price for decision and insert
	always_ff @(posedge clk) begin
		if (in_fire) begin
			price_q <= price[PW-1:0];
		end
	end

	// Output register: load on decision, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			out_count_q <= cnt_wide[COUNT_W-1:0];
			out_total_q <= nxt_total;
			out_ovf_q   <= nxt_ovf;
			out_final_q <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_count = out_count_q;
	assign chosen_total = out_total_q;
	assign overflow     = out_ovf_q;
	assign final_res    = out_final_q;

	// Sorted chain of chosen prices
	bgms_chain #(
		.MAX_ITEMS (MAX_ITEMS),
		.PW        (PW),
		.CW        (CW)
	) u_chain (
		.clk     (clk),
		.op      (cell_op),
		.price   (price_q),
		.occ_cnt (ins_cnt_q),
		.head    (head)
	);

endmodule

### src/bgms_cell.sv
// One cell of the sorted price chain: holds one price, trades with its neighbors.
`timescale 1ns / 1ps
module bgms_cell #(
	parameter int IDX = 0,
	parameter int PW  = 32,
	parameter int CW  = 9
) (
	input  logic              clk,
	input  bgms_pkg::cell_op_t op,
	input  logic [PW-1:0]     price,
	input  logic [CW-1:0]     occ_cnt,
	input  logic [PW-1:0]     left_val,
	input  logic              left_gt,
	input  logic [PW-1:0]     right_val,
	output logic [PW-1:0]     val,
	output logic              gt
);
	import bgms_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [PW-1:0] val_q;

	// The new price belongs at or before this cell when the cell is empty or smaller
	assign gt  = (MY_IDX >= occ_cnt) || (price > val_q);
	assign val = val_q;

	// Shift toward the head on pop, open a slot on insert
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_POP: begin
				val_q <= right_val;
			end
			CELL_INS: begin
				if (gt) begin
					val_q <= left_gt ? left_val : price;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

### src/bgms_chain.sv
// Row of price cells kept in descending order, largest price at the head.
`timescale 1ns / 1ps
module bgms_chain #(
	parameter int MAX_ITEMS = 256,
	parameter int PW        = 32,
	parameter int CW        = 9
) (
	input  logic              clk,
	input  bgms_pkg::cell_op_t op,
	input  logic [PW-1:0]     price,
	input  logic [CW-1:0]     occ_cnt,
	output logic [PW-1:0]     head
);
	import bgms_pkg::*;

	logic [PW-1:0] val_w [MAX_ITEMS];
	logic          gt_w  [MAX_ITEMS];

	// Wire each cell to its neighbors; the first cell sees fixed left values, the last sees itself on the right
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [PW-1:0] lv;
		logic          lg;
		logic [PW-1:0] rv;

		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = val_w[i-1];
			assign lg = gt_w[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign rv = val_w[i];
		end else begin : g_inner
			assign rv = val_w[i+1];
		end

		bgms_cell #(
			.IDX (i),
			.PW  (PW),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.price     (price),
			.occ_cnt   (occ_cnt),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (val_w[i]),
			.gt        (gt_w[i])
		);
	end

	assign head = val_w[0];

endmodule

### dv/tb_budget_greedy_max_count_select_top.sv
// Self-checking testbench for the budget greedy max-count selector top level.
`timescale 1ns / 1ps
module tb_budget_greedy_max_count_select_top;

	import bgms_pkg::*;

	localparam int MAX_ITEMS = MAX_ITEMS_DEF;
	localparam logic [ADDR_W-1:0] BUDGET_ADDR = {REG_BUDGET, 2'b00};
	localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

	typedef struct {
		logic [31:0] price;
		logic        last;
	} offer_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [31:0]        total;
		logic               ovf;
		logic               fin;
	} tally_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [31:0]         price = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [COUNT_W-1:0]  chosen_count;
	logic [31:0]         chosen_total;
	logic                overflow;
	logic                final_res;

	// Predictor state: the chosen prices and the running tallies
	logic [31:0] cur_budget = '0;
	logic [31:0] pick_store [MAX_ITEMS];
	int          pick_count = 0;
	logic [31:0] pick_total = '0;
	logic        pick_ovf = 1'b0;

	offer_t offer_q[$];
	tally_t tally_q[$];
	offer_t drv_offer;
	tally_t want;

	int  queued_total = 0;
	int  beats_in = 0;
	int  results_seen = 0;
	int  budget_writes = 0;
	int  errors = 0;
	bit  calm = 1'b0;

	budget_greedy_max_count_select_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.price        (price),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chosen_count (chosen_count),
		.chosen_total (chosen_total),
		.overflow     (overflow),
		.final_res    (final_res)
	);

	always #2 clk = ~clk;

	// Random idle decision, off during the calm stretch
	function automatic bit pause_now();
		return !calm && ($urandom_range(0, 99) < 21);
	endfunction

	// Greedy selection on one accepted price; queue the tally it produces
	task automatic select_price(input logic [31:0] p, input logic lst);
		int          top;
		logic [32:0] sum;
		tally_t      t;
		sum = {1'b0, pick_total} + {1'b0, p};
		if (p <= cur_budget) begin
			if (sum <= {1'b0, cur_budget}) begin
				if (pick_count < MAX_ITEMS) begin
					pick_store[pick_count] = p;
					pick_count++;
					pick_total = sum[31:0];
				end else begin
					pick_ovf = 1'b1;
				end
			end else if (pick_count > 0) begin
				// swap out the largest chosen price if this one is strictly lower
				top = 0;
				for (int i = 1; i < pick_count; i++)
					if (pick_store[i] > pick_store[top])
						top = i;
				if (p < pick_store[top]) begin
					pick_total = pick_total - pick_store[top] + p;
					pick_store[top] = p;
				end
			end
		end
		t.count = COUNT_W'(pick_count);
		t.total = pick_total;
		t.ovf = pick_ovf;
		t.fin = lst;
		tally_q.insert(tally_q.size(), t);
		if (lst) begin
			pick_count = 0;
			pick_total = '0;
			pick_ovf = 1'b0;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
			errors++;
		end
	endtask

	// Driver: present queued offers, hold a stalled beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			price <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				select_price(price, last);
				beats_in++;
			end
			if (!in_valid || !in_stall) begin
				if (offer_q.size() != 0 && !pause_now()) begin
					drv_offer = offer_q.pop_front();
					in_valid <= 1'b1;
					price <= drv_offer.price;
					last <= drv_offer.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest tally
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (tally_q.size() == 0) begin
					$display("%0t unexpected result beat: count %0d total %0d", $time,
						chosen_count, chosen_total);
					errors++;
				end else begin
					want = tally_q.pop_front();
					check_field("chosen_count", 32'(want.count), 32'(chosen_count));
					check_field("chosen_total", want.total, chosen_total);
					check_field("overflow", 32'(want.ovf), 32'(overflow));
					check_field("final_res", 32'(want.fin), 32'(final_res));
				end
			end
			out_stall <= pause_now();
		end
	end

	task automatic apb_read(output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= BUDGET_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the budget, then read it back
	task automatic program_budget(input logic [31:0] value);
		logic [31:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BUDGET_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_budget = value;
		budget_writes++;
		apb_read(rd);
		check_field("budget readback", value, rd);
	endtask

	task automatic queue_offer(input logic [31:0] p, input logic lst);
		offer_t o;
		o.price = p;
		o.last = lst;
		offer_q.insert(offer_q.size(), o);
		queued_total++;
	endtask

	// Wait until every queued offer has produced its result
	task automatic drain();
		while (results_seen < queued_total)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Prices biased around the current budget
	function automatic logic [31:0] pick_price();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return cur_budget;
			3: return (cur_budget == PRICE_MAX) ? cur_budget : cur_budget + 1;
			4: return $urandom_range(cur_budget / 2, cur_budget);
			default: return $urandom_range(0, cur_budget / 6);
		endcase
	endfunction

	// Random sets of random length; optionally leave the last set open
	task automatic queue_random_sets(input int n_items, input bit keep_open);
		int left;
		left = $urandom_range(1, 14);
		for (int i = 0; i < n_items; i++) begin
			left--;
			queue_offer(pick_price(), (left == 0) || (i == n_items - 1 && !keep_open));
			if (left == 0)
				left = $urandom_range(1, 14);
		end
	endtask

	initial begin
		logic [31:0] rd;
		logic [31:0] budgets [8];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read(rd);
		check_field("budget after reset", 32'd0, rd);

		// Directed: exact fit, above budget, tie with the largest, replacement
		program_budget(32'd100);
		queue_offer(32'd0, 1'b0);
		queue_offer(32'd40, 1'b0);
		queue_offer(32'd60, 1'b0);
		queue_offer(32'd100, 1'b0);
		queue_offer(32'd101, 1'b0);
		queue_offer(PRICE_MAX, 1'b0);
		queue_offer(32'd60, 1'b0);
		queue_offer(32'd30, 1'b0);
		queue_offer(32'd30, 1'b1);
		drain();

		// Directed: zero budget
		program_budget(32'd0);
		queue_offer(32'd0, 1'b0);
		queue_offer(32'd1, 1'b0);
		queue_offer(32'd0, 1'b1);
		drain();

		// Directed: full-range prices, set left open across a budget cut
		program_budget(PRICE_MAX);
		queue_offer(PRICE_MAX, 1'b0);
		queue_offer(32'd1, 1'b0);
		queue_offer(32'hFFFF_FFFE, 1'b0);
		queue_offer(32'd2, 1'b1);
		queue_offer(32'h8000_0000, 1'b0);
		drain();
		program_budget(32'd10);
		queue_offer(32'd11, 1'b0);
		queue_offer(32'd3, 1'b0);
		queue_offer(32'd7, 1'b0);
		queue_offer(32'd1, 1'b1);
		drain();

		// Random phases over a spread of budgets
		budgets[0] = $urandom_range(1, 40);
		budgets[1] = PRICE_MAX;
		budgets[2] = $urandom_range(100, 5000);
		budgets[3] = $urandom();
		budgets[4] = 32'd1;
		budgets[5] = $urandom_range(1000, 100000);
		budgets[6] = 32'd0;
		budgets[7] = $urandom();
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 2);
			program_budget(budgets[ph]);
			queue_random_sets(60, $urandom_range(0, 2) == 0);
			drain();
		end
		calm = 1'b0;

		// Fill the store past its depth, then force a replacement while full
		program_budget(PRICE_MAX);
		queue_offer(32'hF000_0000, 1'b0);
		for (int i = 0; i < MAX_ITEMS + 4; i++)
			queue_offer($urandom_range(0, 3), 1'b0);
		queue_offer(32'h2000_0000, 1'b0);
		queue_offer(32'd5, 1'b0);
		queue_offer(32'd0, 1'b1);
		queue_random_sets(20, 1'b0);
		drain();

		repeat (10) @(posedge clk);
		if (tally_q.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, tally_q.size());
			errors++;
		end
		$display("Covered %0d price beats and %0d result beats over %0d budget writes,",
			beats_in, results_seen, budget_writes);
		$display("including a full store, ties, replacements and budget cuts mid-set.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
